// ----- hdl/llq_pkg.sv -----
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types, constants and helpers of the linked-list queue with free list.
// ----------------------------------------------------------------------------
package llq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ITEM_W     = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PTR_W      = $clog2(DEPTH + 1);

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ITEM_W-1:0]     item_t;

  // pointer value DEPTH marks the end of a list
  localparam ptr_t NULL_PTR = PTR_W'(DEPTH);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // request from the sequencer to the node store
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  link_we;
    addr_t link_waddr;
    ptr_t  link_wdata;
    logic  val_we;
    addr_t val_waddr;
    data_t val_wdata;
  } store_req_t;

  function automatic logic ptr_ok(ptr_t p);
    return p < PTR_W'(DEPTH);
  endfunction

  function automatic addr_t ptr_addr(ptr_t p);
    return p[ADDR_W-1:0];
  endfunction

  function automatic data_t item_to_data(item_t v);
    logic [DATA_WIDTH+ITEM_W-1:0] w;
    w = {{DATA_WIDTH{1'b0}}, v};
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic item_t data_to_item(data_t d);
    logic [DATA_WIDTH+ITEM_W-1:0] w;
    w = {{ITEM_W{1'b0}}, d};
    return w[ITEM_W-1:0];
  endfunction

endpackage

// ----- hdl/linked_list_queue_free_list.sv -----
// ----------------------------------------------------------------------------
// linked_list_queue_free_list
// FIFO queue kept as a singly linked list in a node store, with a free list
// threading the unused nodes. Overflow drops the item, underflow is flagged.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  meaning
//  in        in_valid in_ready kind value  input      enqueue value / dequeue
//  out       out_valid out_ready status    output     one result per request
//            item is_empty
//
// A request with a valid pointer issues the link read in its transfer cycle;
// S_ENQ or S_DEQ then uses the registered link and writes a link back.
// No new request is taken until the current one has loaded its result.
// Reset clears the per-entry written flags at once; no clearing pass.
// A result waiting in the output register stalls the write-back step and the
// error state; the next request is not taken until that step is done.
module linked_list_queue_free_list (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic signed [31:0]  item,
  output logic                is_empty
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_DEQ  = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  logic [1:0]          state;
  llq_pkg::ptr_t       free_head;
  llq_pkg::ptr_t       head_ptr;
  llq_pkg::ptr_t       tail_ptr;
  llq_pkg::addr_t      cur;
  logic [1:0]          err_status;

  llq_pkg::store_req_t req;
  llq_pkg::ptr_t       link_rdata;
  llq_pkg::data_t      val_rdata;

  logic in_xfer;
  logic slot_free;
  logic load_out;
  logic fh_ok;
  logic head_ok;
  logic tail_ok;

  assign fh_ok     = llq_pkg::ptr_ok(free_head);
  assign head_ok   = llq_pkg::ptr_ok(head_ptr);
  assign tail_ok   = llq_pkg::ptr_ok(tail_ptr);
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign load_out  = slot_free && (state != S_IDLE);

  llq_store u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .link_rdata (link_rdata),
    .val_rdata  (val_rdata)
  );

  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer && kind == llq_pkg::KIND_ENQ && fh_ok) begin
          // read the next free node, store the value, link after the tail
          req.rd_en      = 1'b1;
          req.rd_addr    = llq_pkg::ptr_addr(free_head);
          req.val_we     = 1'b1;
          req.val_waddr  = llq_pkg::ptr_addr(free_head);
          req.val_wdata  = llq_pkg::item_to_data(value);
          req.link_we    = tail_ok;
          req.link_waddr = llq_pkg::ptr_addr(tail_ptr);
          req.link_wdata = free_head;
        end else if (in_xfer && kind == llq_pkg::KIND_DEQ && head_ok) begin
          req.rd_en   = 1'b1;
          req.rd_addr = llq_pkg::ptr_addr(head_ptr);
        end
      end
      S_ENQ: begin
        if (slot_free) begin
          req.link_we    = 1'b1;
          req.link_waddr = cur;
          req.link_wdata = llq_pkg::NULL_PTR;
        end
      end
      S_DEQ: begin
        if (slot_free) begin
          // freed node goes back on top of the free list
          req.link_we    = 1'b1;
          req.link_waddr = cur;
          req.link_wdata = free_head;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      head_ptr   <= llq_pkg::NULL_PTR;
      tail_ptr   <= llq_pkg::NULL_PTR;
      cur        <= '0;
      err_status <= llq_pkg::ST_OK;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (kind == llq_pkg::KIND_ENQ) begin
              if (fh_ok) begin
                cur      <= llq_pkg::ptr_addr(free_head);
                tail_ptr <= free_head;
                if (!tail_ok) begin
                  head_ptr <= free_head;
                end
                state <= S_ENQ;
              end else begin
                err_status <= llq_pkg::ST_OVERFLOW;
                state      <= S_ERR;
              end
            end else begin
              if (head_ok) begin
                cur   <= llq_pkg::ptr_addr(head_ptr);
                state <= S_DEQ;
              end else begin
                head_ptr   <= llq_pkg::NULL_PTR;
                err_status <= llq_pkg::ST_UNDERFLOW;
                state      <= S_ERR;
              end
            end
          end
        end
        S_ENQ: begin
          if (slot_free) begin
            free_head <= link_rdata;
            state     <= S_IDLE;
          end
        end
        S_DEQ: begin
          if (slot_free) begin
            free_head <= llq_pkg::ptr_t'(cur);
            if (llq_pkg::ptr_ok(link_rdata)) begin
              head_ptr <= link_rdata;
            end else begin
              head_ptr <= llq_pkg::NULL_PTR;
              tail_ptr <= llq_pkg::NULL_PTR;
            end
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (state)
        S_ENQ: begin
          status   <= llq_pkg::ST_OK;
          item     <= '0;
          is_empty <= 1'b0;
        end
        S_DEQ: begin
          status   <= llq_pkg::ST_OK;
          item     <= llq_pkg::data_to_item(val_rdata);
          is_empty <= !llq_pkg::ptr_ok(link_rdata);
        end
        default: begin
          status   <= err_status;
          item     <= '0;
          is_empty <= !head_ok;
        end
      endcase
    end
  end

  // head and tail are null together
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> head_ok == tail_ok)
    else $error("head and tail pointers disagree on empty queue");

  // the free-list head is never the queue head
  a_lists_apart: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && head_ok && fh_ok |-> free_head != head_ptr)
    else $error("free list head is also queue head");

  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && item != 0 |-> status == llq_pkg::ST_OK)
    else $error("nonzero item on a failed request");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == llq_pkg::ST_UNDERFLOW |-> is_empty)
    else $error("underflow reported on a non-empty queue");

endmodule

// ----- hdl/llq_store.sv -----
// ----------------------------------------------------------------------------
// llq_store
// Node store: link memory and value memory, one read and one write port each,
// registered read data. Link entries never written read as their reset link.
// ----------------------------------------------------------------------------
module llq_store (
  input  logic               clk,
  input  logic               rst,
  input  llq_pkg::store_req_t req,
  output llq_pkg::ptr_t      link_rdata,
  output llq_pkg::data_t     val_rdata
);

  llq_pkg::ptr_t  link_mem [llq_pkg::DEPTH];
  llq_pkg::data_t val_mem  [llq_pkg::DEPTH];

  logic [llq_pkg::DEPTH-1:0] link_written;

  llq_pkg::ptr_t  link_q;
  llq_pkg::data_t val_q;
  logic           written_q;
  llq_pkg::addr_t raddr_q;

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.val_we) begin
      val_mem[req.val_waddr] <= req.val_wdata;
    end
    if (req.rd_en) begin
      link_q  <= link_mem[req.rd_addr];
      val_q   <= val_mem[req.rd_addr];
      raddr_q <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_written <= '0;
      written_q    <= 1'b0;
    end else begin
      if (req.link_we) begin
        link_written[req.link_waddr] <= 1'b1;
      end
      if (req.rd_en) begin
        written_q <= link_written[req.rd_addr];
      end
    end
  end

  // unwritten entry i links to i+1, the last one to null
  assign link_rdata = written_q ? link_q
                                : llq_pkg::ptr_t'(raddr_q) + llq_pkg::ptr_t'(1);
  assign val_rdata  = val_q;

endmodule
